/* sv/pba_pkg.sv */
// Shared types and constants for the page bitmap allocator.
package pba_pkg;

   localparam int REQ_W           = 17;
   localparam int IDX_W           = 6;
   localparam int MAP_DEPTH       = 64;
   localparam int CNT_W           = 7;
   localparam int FREE_W          = 17;
   localparam logic [FREE_W-1:0] FREE_MAX = {FREE_W{1'b1}};

   localparam int DEF_PAGE_BYTES  = 1024;
   localparam int DEF_TOTAL_BYTES = 65536;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SETTLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic settle;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

endpackage

/* sv/page_bitmap_allocator_unit.sv */
// Top level of the bitmap first-fit page allocator.
//
// Usage: raise start with a byte count on req_request_bytes; the item is taken
// at a clock edge where start is high and busy is low. The wanted page count
// is the byte count divided by PAGE_BYTES, rounded down. Free pages are taken
// lowest index first; each one comes out as one result on the rsp_ ports,
// marked by rsp_strobe for exactly one cycle. The final result of an item has
// rsp_last_of_run set. A zero-page item, or one that finds no free page, gives
// a single result with rsp_page_valid low. rsp_short_flag is set on every
// result of an item that wanted more pages than were free; rsp_free_bytes
// holds the free bytes left once the whole item is done (saturating).
// Sequence: the page count comes from a constant reciprocal multiply in the
// divide state, then a settle state, then one result per cycle from a
// priority encoder over the page map, registered out of the emit state.
// busy stays high through divide, settle and emit, so no new item is taken
// until the final result is issued. busy drops with the last result in
// flight; a new item may be taken at the edge that ends its final strobe.
// Reset frees every page of the pool. The receiver cannot stall the block.
module page_bitmap_allocator_unit #(
   parameter int PAGE_BYTES  = pba_pkg::DEF_PAGE_BYTES,
   parameter int TOTAL_BYTES = pba_pkg::DEF_TOTAL_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [pba_pkg::REQ_W-1:0]   req_request_bytes,
   output logic                        rsp_strobe,
   output logic [pba_pkg::IDX_W-1:0]   rsp_page_index,
   output logic                        rsp_page_valid,
   output logic                        rsp_last_of_run,
   output logic                        rsp_short_flag,
   output logic [pba_pkg::FREE_W-1:0]  rsp_free_bytes
);

   pba_pkg::cmd_type    cmd;
   pba_pkg::status_type status;

   // sequencer: idle -> divide -> settle -> emit
   pba_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // page map, free counter, page count divide and result registers
   pba_dp #(
      .PAGE_BYTES  (PAGE_BYTES),
      .TOTAL_BYTES (TOTAL_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_bytes  (req_request_bytes),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_index  (rsp_page_index),
      .rsp_valid  (rsp_page_valid),
      .rsp_last   (rsp_last_of_run),
      .rsp_short  (rsp_short_flag),
      .rsp_free   (rsp_free_bytes)
   );

endmodule

/* sv/pba_ctrl.sv */
// Sequencer for the page bitmap allocator: divide, settle, then emit pages.
module pba_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  pba_pkg::status_type status,
   output pba_pkg::cmd_type    cmd,
   output logic                busy
);

   pba_pkg::state_type state_ff;
   pba_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pba_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         pba_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = pba_pkg::ST_DIVIDE;
            end
         end
         pba_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            state_in     = pba_pkg::ST_SETTLE;
         end
         pba_pkg::ST_SETTLE: begin
            cmd.settle = 1'b1;
            state_in   = pba_pkg::ST_EMIT;
         end
         pba_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.last) begin
               state_in = pba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pba_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != pba_pkg::ST_IDLE);

endmodule

/* sv/pba_dp.sv */
// Datapath: page count divide, used-page map, free counter, result registers.
module pba_dp #(
   parameter int PAGE_BYTES  = pba_pkg::DEF_PAGE_BYTES,
   parameter int TOTAL_BYTES = pba_pkg::DEF_TOTAL_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pba_pkg::cmd_type                 cmd,
   input  logic [pba_pkg::REQ_W-1:0]        req_bytes,
   output pba_pkg::status_type              status,
   output logic                             rsp_strobe,
   output logic [pba_pkg::IDX_W-1:0]        rsp_index,
   output logic                             rsp_valid,
   output logic                             rsp_last,
   output logic                             rsp_short,
   output logic [pba_pkg::FREE_W-1:0]       rsp_free
);

   localparam int RAW_PAGES  = TOTAL_BYTES / PAGE_BYTES;
   localparam int POOL_PAGES = (RAW_PAGES > pba_pkg::MAP_DEPTH) ? pba_pkg::MAP_DEPTH
                                                               : RAW_PAGES;
   localparam int PW  = $clog2(PAGE_BYTES + 1);
   localparam int PRW = pba_pkg::CNT_W + PW;
   localparam int CW  = (PRW > pba_pkg::REQ_W) ? PRW : pba_pkg::REQ_W;
   localparam logic [PW-1:0] PAGE_K = PW'(PAGE_BYTES);

   // reciprocal gives an exact floor divide of any REQ_W-bit size
   localparam int     RSH     = pba_pkg::REQ_W + $clog2(PAGE_BYTES);
   localparam int     RW      = pba_pkg::REQ_W + 1;
   localparam int     QPW     = pba_pkg::REQ_W + RW;
   localparam longint RECIP_L = ((longint'(1) << RSH) + longint'(PAGE_BYTES - 1))
                                / longint'(PAGE_BYTES);
   localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

   logic [pba_pkg::MAP_DEPTH-1:0] used_ff, used_in;
   logic [pba_pkg::CNT_W-1:0]     free_ff, free_in;
   logic [pba_pkg::REQ_W-1:0]     req_ff, req_in;
   logic [pba_pkg::CNT_W-1:0]     quot_ff, quot_in;
   logic [pba_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                          short_ff, short_in;
   logic [pba_pkg::FREE_W-1:0]    fb_ff, fb_in;

   logic                          strobe_ff;
   logic [pba_pkg::IDX_W-1:0]     index_ff;
   logic                          valid_ff, last_ff, rshort_ff;
   logic [pba_pkg::FREE_W-1:0]    rfree_ff;

   logic [QPW-1:0]                quot_prod;
   logic [QPW-1:0]                quot_full;
   logic [pba_pkg::CNT_W-1:0]     got;
   logic [pba_pkg::CNT_W-1:0]     left;
   logic [PRW-1:0]                left_prod;
   logic [pba_pkg::IDX_W-1:0]     pick;
   logic                          have_page;

   // reset map: pages beyond the pool read as permanently used
   function automatic logic [pba_pkg::MAP_DEPTH-1:0] reset_map();
      logic [pba_pkg::MAP_DEPTH-1:0] m;
      for (int i = 0; i < pba_pkg::MAP_DEPTH; i++) begin
         m[i] = (i >= POOL_PAGES);
      end
      return m;
   endfunction

   // lowest free page
   always_comb begin
      pick = '0;
      for (int i = pba_pkg::MAP_DEPTH - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            pick = pba_pkg::IDX_W'(i);
         end
      end
   end

   assign quot_prod  = QPW'(req_ff) * QPW'(RECIP);
   assign quot_full  = quot_prod >> RSH;
   assign got        = (quot_ff > free_ff) ? free_ff : quot_ff;
   assign left       = free_ff - got;
   assign left_prod  = PRW'(left) * PRW'(PAGE_K);
   assign have_page  = (count_ff != '0);

   always_comb begin
      used_in  = used_ff;
      free_in  = free_ff;
      req_in   = req_ff;
      quot_in  = quot_ff;
      count_in = count_ff;
      short_in = short_ff;
      fb_in    = fb_ff;
      if (cmd.load) begin
         req_in  = req_bytes;
         quot_in = '0;
      end
      if (cmd.div_step) begin
         // page count, capped at the counter width
         if (quot_full > QPW'({pba_pkg::CNT_W{1'b1}})) begin
            quot_in = '1;
         end else begin
            quot_in = pba_pkg::CNT_W'(quot_full);
         end
      end
      if (cmd.settle) begin
         count_in = got;
         short_in = (quot_ff > free_ff);
         free_in  = left;
         if (CW'(left_prod) > CW'(pba_pkg::FREE_MAX)) begin
            fb_in = pba_pkg::FREE_MAX;
         end else begin
            fb_in = pba_pkg::FREE_W'(left_prod);
         end
      end
      if (cmd.emit && have_page) begin
         used_in[pick] = 1'b1;
         count_in      = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= reset_map();
         free_ff   <= pba_pkg::CNT_W'(POOL_PAGES);
         strobe_ff <= 1'b0;
      end else begin
         used_ff   <= used_in;
         free_ff   <= free_in;
         strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      quot_ff  <= quot_in;
      count_ff <= count_in;
      short_ff <= short_in;
      fb_ff    <= fb_in;
      if (cmd.emit) begin
         index_ff  <= have_page ? pick : '0;
         valid_ff  <= have_page;
         last_ff   <= (count_ff <= pba_pkg::CNT_W'(1));
         rshort_ff <= short_ff;
         rfree_ff  <= fb_ff;
      end
   end

   assign status.last = (count_ff <= pba_pkg::CNT_W'(1));

   assign rsp_strobe = strobe_ff;
   assign rsp_index  = index_ff;
   assign rsp_valid  = valid_ff;
   assign rsp_last   = last_ff;
   assign rsp_short  = rshort_ff;
   assign rsp_free   = rfree_ff;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the bitmap first-fit page allocator.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Pool geometry as the block sees it with default parameters.
   localparam int PAGE_BYTES = pba_pkg::DEF_PAGE_BYTES;
   localparam int RAW_PAGES  = pba_pkg::DEF_TOTAL_BYTES / pba_pkg::DEF_PAGE_BYTES;
   localparam int POOL_PAGES = (RAW_PAGES > pba_pkg::MAP_DEPTH) ?
                               pba_pkg::MAP_DEPTH : RAW_PAGES;
   localparam logic [pba_pkg::MAP_DEPTH-1:0] POOL_MASK =
      (POOL_PAGES >= pba_pkg::MAP_DEPTH) ? '1 : ((64'd1 << POOL_PAGES) - 64'd1);
   // Longest legal stretch without any handshake is a sender gap plus the
   // lead-in of one item up to its first result; this is many times that.
   localparam int IDLE_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [pba_pkg::IDX_W-1:0]  index;
      logic                       valid;
      logic                       last;
      logic                       short_run;
      logic [pba_pkg::FREE_W-1:0] free_bytes;
   } page_result_type;

   // One request item; drain holds it back until every result is in.
   typedef struct {
      logic [pba_pkg::REQ_W-1:0] bytes;
      bit                        drain;
   } alloc_req_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic [pba_pkg::REQ_W-1:0]  req_request_bytes = '0;
   logic                       busy;
   logic                       rsp_strobe;
   logic [pba_pkg::IDX_W-1:0]  rsp_page_index;
   logic                       rsp_page_valid;
   logic                       rsp_last_of_run;
   logic                       rsp_short_flag;
   logic [pba_pkg::FREE_W-1:0] rsp_free_bytes;

   alloc_req_type   pending_reqs[$];
   page_result_type expected_pages[$];
   logic [pba_pkg::MAP_DEPTH-1:0] used_pages = '0;

   int items_sent = 0;
   int items_taken = 0;
   int idle_cycles = 0;
   int fail_count = 0;
   int results_seen = 0;
   int pages_granted = 0;
   int zero_page_items = 0;
   int short_items = 0;
   int burst_left = 1;
   int gap_left = 0;

   page_bitmap_allocator_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_request_bytes (req_request_bytes),
      .rsp_strobe        (rsp_strobe),
      .rsp_page_index    (rsp_page_index),
      .rsp_page_valid    (rsp_page_valid),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_short_flag    (rsp_short_flag),
      .rsp_free_bytes    (rsp_free_bytes)
   );

   // 4 ns clock.
   initial begin
      forever #2 clock = ~clock;
   end

   // Synchronous reset, released on a falling edge.
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Appends one request item to the driver's queue.
   task automatic queue_req(input logic [pba_pkg::REQ_W-1:0] bytes, input bit drain);
      alloc_req_type item;
      item.bytes = bytes;
      item.drain = drain;
      pending_reqs = {pending_reqs, item};
   endtask

   // First-fit allocation over the shadow page map; queues every result
   // the item should produce, in order.
   task automatic allocate_pages(input logic [pba_pkg::REQ_W-1:0] bytes);
      int unsigned     wanted;
      int              taken_idx[$];
      int              free_count;
      logic            shortfall;
      logic [31:0]     free_total;
      page_result_type res;
      wanted = bytes / PAGE_BYTES;
      free_count = 0;
      for (int i = 0; i < pba_pkg::MAP_DEPTH && taken_idx.size() < wanted; i++) begin
         if (POOL_MASK[i] && !used_pages[i]) begin
            used_pages[i] = 1'b1;
            taken_idx = {taken_idx, i};
         end
      end
      shortfall = (taken_idx.size() < wanted);
      for (int i = 0; i < pba_pkg::MAP_DEPTH; i++)
         free_count += (POOL_MASK[i] && !used_pages[i]);
      free_total = free_count * PAGE_BYTES;
      res.free_bytes = (free_total > pba_pkg::FREE_MAX) ? pba_pkg::FREE_MAX
                                                        : free_total[pba_pkg::FREE_W-1:0];
      res.short_run = shortfall;
      if (wanted == 0)
         zero_page_items++;
      if (shortfall)
         short_items++;
      if (taken_idx.size() == 0) begin
         // zero-page item or no page left: one empty reply
         res.index = '0;
         res.valid = 1'b0;
         res.last  = 1'b1;
         expected_pages = {expected_pages, res};
      end else begin
         foreach (taken_idx[k]) begin
            res.index = pba_pkg::IDX_W'(taken_idx[k]);
            res.valid = 1'b1;
            res.last  = (k == taken_idx.size() - 1);
            expected_pages = {expected_pages, res};
         end
      end
   endtask

   // Driver: presents queued items in bursts separated by random gaps.
   // A gap counts cycles after the previous item is taken, so start rises
   // at varied points of the block's busy window.
   always @(negedge clock) begin
      logic                      next_start;
      logic [pba_pkg::REQ_W-1:0] next_bytes;
      alloc_req_type             item;
      next_start = start;
      next_bytes = req_request_bytes;
      if (reset) begin
         next_start = 1'b0;
      end else if (!(start && items_sent != items_taken)) begin
         next_start = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_reqs.size() != 0 &&
                      !(pending_reqs[0].drain && expected_pages.size() != 0)) begin
            item = pending_reqs.pop_front();
            next_start = 1'b1;
            next_bytes = item.bytes;
            items_sent++;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 20);
            end
         end
      end
      start <= next_start;
      req_request_bytes <= next_bytes;
   end

   // Monitor: checks each strobed result against the oldest expectation,
   // then predicts the item taken at this edge.
   always @(posedge clock) begin
      logic            progress;
      page_result_type seen;
      page_result_type want;
      progress = 1'b0;
      if (!reset) begin
         if (rsp_strobe) begin
            progress = 1'b1;
            results_seen++;
            seen = '{rsp_page_index, rsp_page_valid, rsp_last_of_run,
                     rsp_short_flag, rsp_free_bytes};
            if (seen.valid === 1'b1)
               pages_granted++;
            if (expected_pages.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("%0t: result with nothing expected", $realtime);
                  $display("   got idx=%0d valid=%b last=%b short=%b free=%0d",
                           seen.index, seen.valid, seen.last,
                           seen.short_run, seen.free_bytes);
               end
            end else begin
               want = expected_pages.pop_front();
               if (seen.index !== want.index || seen.valid !== want.valid ||
                   seen.last !== want.last || seen.short_run !== want.short_run ||
                   seen.free_bytes !== want.free_bytes) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS) begin
                     $display("%0t: mismatch exp idx=%0d valid=%b last=%b short=%b free=%0d",
                              $realtime, want.index, want.valid, want.last,
                              want.short_run, want.free_bytes);
                     $display("   got idx=%0d valid=%b last=%b short=%b free=%0d",
                              seen.index, seen.valid, seen.last,
                              seen.short_run, seen.free_bytes);
                  end
               end
            end
         end
         if (start && !busy) begin
            progress = 1'b1;
            allocate_pages(req_request_bytes);
            items_taken++;
         end
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
   end

   // Watchdog: a run with no handshake for too long has hung.
   initial begin
      while (idle_cycles < IDLE_LIMIT)
         @(negedge clock);
      $display("timeout: no item or result for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // Stimulus and end of run.
   initial begin
      int pick;
      logic [pba_pkg::REQ_W-1:0] bytes;
      logic [pba_pkg::REQ_W-1:0] opening [9];

      // Opening directed items: zero-page sizes at both ends of the page,
      // single pages at both ends, multi-page runs, an odd low pattern.
      opening = '{17'd0, 17'd1023, 17'd1024, 17'd2047, 17'd4101, 17'd0, 17'd1,
                  17'h155, 17'd3072};
      foreach (opening[i])
         queue_req(opening[i], 1'b0);

      // Random part: early on mostly zero-page and small items so the pool
      // fills slowly; later large sizes, up to the top of the field, which
      // drive the pool into shortfall. A few items wait for a full drain.
      for (int n = 0; n < 340; n++) begin
         pick = $urandom_range(0, 99);
         if (n < 200) begin
            if (pick < 82)
               bytes = pba_pkg::REQ_W'($urandom_range(0, 1023));
            else
               bytes = pba_pkg::REQ_W'($urandom_range(1024, 3071));
         end else begin
            if (pick < 70)
               bytes = pba_pkg::REQ_W'($urandom_range(0, 1023));
            else if (pick < 85)
               bytes = pba_pkg::REQ_W'($urandom_range(1024, 4095));
            else
               bytes = pba_pkg::REQ_W'($urandom_range(0, 131071));
         end
         queue_req(bytes, (n % 60 == 59));
      end

      // Closing directed items: whole pool asked for (partial or total
      // shortfall), nothing left, size above range, zero pages when full.
      queue_req(17'd65536, 1'b1);
      queue_req(17'd1024, 1'b0);
      queue_req(17'd131071, 1'b0);
      queue_req(17'd0, 1'b0);
      queue_req(17'd65535, 1'b0);
      queue_req(17'd1023, 1'b0);

      wait (!reset);
      while (pending_reqs.size() != 0 || items_sent != items_taken)
         @(posedge clock);
      while (expected_pages.size() != 0)
         @(posedge clock);
      // Wait out a full item as well to catch any stray result.
      repeat (80) @(posedge clock);
      if (expected_pages.size() != 0) begin
         fail_count++;
         $display("%0d expected results never arrived", expected_pages.size());
      end

      $display("covered %0d items (%0d zero-page, %0d short), %0d results, %0d pages",
               items_taken, zero_page_items, short_items, results_seen, pages_granted);
      $display("pages still free at end: %0d of %0d, errors: %0d",
               $countones(~used_pages & POOL_MASK), POOL_PAGES, fail_count);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
